FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file smds_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define SMDS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define SMDS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: sv/smds_pkg.sv
`default_nettype none

package smds_pkg;

    localparam int VAL_W    = 12;
    localparam int CNT_W    = 17;
    localparam int EPOCH_W  = 8;
    localparam int RECIP_SH = 13;
    localparam int REM_W    = 18;

    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef struct packed {
        logic valid;
        logic last;
    } item_ctl_t;

endpackage

`default_nettype wire

FILE: sv/smds_index.sv
`default_nettype none

module smds_index #(
    parameter int VALUE_COUNT = 4096,
    parameter int AW          = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic [smds_pkg::VAL_W-1:0]    value,
    input  logic                          last_item,
    input  logic                          hold,
    input  logic                          s2_adv,
    output logic                          item_stall,
    output smds_pkg::item_ctl_t           s2_ctl,
    output logic [AW-1:0]                 s2_addr
);
    import smds_pkg::*;

    localparam int RECIP_W = RECIP_SH + 1;
    localparam int PROD_W  = VAL_W + RECIP_W;
    localparam int QV_W    = VAL_W + 17;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / VALUE_COUNT);
    localparam logic [REM_W-1:0]   VC_R  = REM_W'(VALUE_COUNT);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic [VAL_W-1:0]  s1_val_reg;
    logic [VAL_W-1:0]  s1_q_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_last_reg;
    logic [AW-1:0]     s2_addr_reg;

    logic              accept;
    logic              s1_adv;
    logic              s2_ready;
    logic [PROD_W-1:0] prod;
    logic [QV_W-1:0]   qv;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  rem_fix;

    // value mod VALUE_COUNT: reciprocal estimate, then one correction
    assign prod     = PROD_W'(value) * PROD_W'(RECIP);
    assign qv       = QV_W'(s1_q_reg) * QV_W'(VALUE_COUNT);
    assign rem      = REM_W'(s1_val_reg) - qv[REM_W-1:0];
    assign rem_fix  = (rem >= VC_R) ? (rem - VC_R) : rem;

    assign s2_ready   = !s2_valid_reg || s2_adv;
    assign s1_adv     = s1_valid_reg && s2_ready;
    assign item_stall = hold || (s1_valid_reg && !s1_adv);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_val_reg  <= value;
            s1_last_reg <= last_item;
            s1_q_reg    <= prod[RECIP_SH +: VAL_W];
        end
        if (s1_adv)
        begin
            s2_addr_reg <= rem_fix[AW-1:0];
            s2_last_reg <= s1_last_reg;
        end
    end

    assign s2_ctl.valid = s2_valid_reg;
    assign s2_ctl.last  = s2_last_reg;
    assign s2_addr      = s2_addr_reg;

endmodule

`default_nettype wire

FILE: sv/smds_ram.sv
`default_nettype none

module smds_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 41
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] store [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/smds_update.sv
`default_nettype none

module smds_update #(
    parameter int VALUE_COUNT = 4096,
    parameter int MAX_LEN     = 65536,
    parameter int AW          = 12,
    parameter int PW          = 16,
    parameter int DW          = 41
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smds_pkg::item_ctl_t           s2_ctl,
    input  logic [AW-1:0]                 s2_addr,
    input  logic [DW-1:0]                 rdata,
    input  logic                          res_stall,
    output logic                          s2_adv,
    output logic                          hold,
    output logic                          we,
    output logic [AW-1:0]                 waddr,
    output logic [DW-1:0]                 wdata,
    output logic                          res_valid,
    output logic [smds_pkg::CNT_W-1:0]    degree_so_far,
    output logic [smds_pkg::CNT_W-1:0]    shortest_length,
    output logic                          is_final,
    output logic                          overflow
);
    import smds_pkg::*;

    localparam int PCW = $clog2(MAX_LEN + 1);
    localparam int SPW = (PW + 1 > CNT_W) ? (PW + 1) : CNT_W;
    localparam logic [PCW-1:0] LEN_LIM  = PCW'(MAX_LEN);
    localparam logic [PW-1:0]  POS_LAST = PW'(MAX_LEN - 1);
    localparam logic [AW-1:0]  ADDR_END = AW'(VALUE_COUNT - 1);

    logic                s3_valid_reg, s3_valid_next;
    logic                s3_last_reg;
    logic [AW-1:0]       s3_addr_reg;
    logic                fwd_reg;
    logic [DW-1:0]       fwd_data_reg;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic                clr_reg, clr_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [PCW-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]    max_reg, max_next;
    logic [CNT_W-1:0]    best_reg, best_next;
    logic                ovf_reg, ovf_next;
    logic                res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]    res_deg_reg;
    logic [CNT_W-1:0]    res_len_reg;
    logic                res_final_reg;
    logic                res_ovf_reg;

    logic                s3_fire;
    logic                wrap;
    logic                s3_ready;
    logic [DW-1:0]       entry;
    logic                hit;
    logic [CNT_W-1:0]    cnt_old;
    logic [CNT_W-1:0]    cnt_new;
    logic [PW-1:0]       first_new;
    logic                ovf_now;
    logic [PW-1:0]       idx;
    logic [SPW-1:0]      span_w;
    logic [CNT_W-1:0]    span;
    logic [CNT_W-1:0]    deg_upd;
    logic [CNT_W-1:0]    best_upd;
    logic                ovf_upd;

    assign s3_fire  = s3_valid_reg && (!res_valid_reg || !res_stall) && !clr_reg;
    assign wrap     = s3_last_reg && (epoch_reg == EPOCH_LAST);
    assign s3_ready = !clr_reg && (!s3_valid_reg || s3_fire) && !(s3_fire && wrap);
    assign s2_adv   = s2_ctl.valid && s3_ready;
    assign hold     = clr_reg;

    // entry written by the item just ahead bypasses the stale read
    assign entry   = fwd_reg ? fwd_data_reg : rdata;
    assign hit     = (entry[DW-1 -: EPOCH_W] == epoch_reg);
    assign cnt_old = hit ? entry[PW +: CNT_W] : '0;
    assign cnt_new = (cnt_old == CNT_MAX) ? cnt_old : (cnt_old + CNT_W'(1));

    assign ovf_now   = (pos_reg >= LEN_LIM);
    assign idx       = ovf_now ? POS_LAST : pos_reg[PW-1:0];
    assign first_new = hit ? entry[PW-1:0] : idx;
    assign span_w    = SPW'(idx) - SPW'(first_new) + SPW'(1);
    assign span      = (span_w > SPW'(CNT_MAX)) ? CNT_MAX : span_w[CNT_W-1:0];
    assign ovf_upd   = ovf_reg || ovf_now;

    always_comb
    begin
        deg_upd  = max_reg;
        best_upd = best_reg;
        if (cnt_new > max_reg)
        begin
            deg_upd  = cnt_new;
            best_upd = span;
        end
        else if ((cnt_new == max_reg) && (span < best_reg))
        begin
            best_upd = span;
        end
    end

    always_comb
    begin
        s3_valid_next  = s3_valid_reg;
        epoch_next     = epoch_reg;
        clr_next       = clr_reg;
        clr_addr_next  = clr_addr_reg;
        pos_next       = pos_reg;
        max_next       = max_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (s2_adv)
        begin
            s3_valid_next = 1'b1;
        end
        else if (s3_fire)
        begin
            s3_valid_next = 1'b0;
        end

        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == ADDR_END)
            begin
                clr_next = 1'b0;
            end
        end

        if (s3_fire)
        begin
            res_valid_next = 1'b1;
            if (s3_last_reg)
            begin
                pos_next  = '0;
                max_next  = '0;
                best_next = '0;
                ovf_next  = 1'b0;
                if (wrap)
                begin
                    epoch_next    = EPOCH_FIRST;
                    clr_next      = 1'b1;
                    clr_addr_next = '0;
                end
                else
                begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                end
            end
            else
            begin
                pos_next  = ovf_now ? pos_reg : (pos_reg + PCW'(1));
                max_next  = deg_upd;
                best_next = best_upd;
                ovf_next  = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            epoch_reg     <= EPOCH_FIRST;
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            max_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= s3_valid_next;
            epoch_reg     <= epoch_next;
            clr_reg       <= clr_next;
            clr_addr_reg  <= clr_addr_next;
            pos_reg       <= pos_next;
            max_reg       <= max_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_addr_reg  <= s2_addr;
            s3_last_reg  <= s2_ctl.last;
            fwd_reg      <= s3_fire && (s3_addr_reg == s2_addr);
            fwd_data_reg <= wdata;
        end
        if (s3_fire)
        begin
            res_deg_reg   <= deg_upd;
            res_len_reg   <= best_upd;
            res_final_reg <= s3_last_reg;
            res_ovf_reg   <= ovf_upd;
        end
    end

    assign we    = clr_reg || s3_fire;
    assign waddr = clr_reg ? clr_addr_reg : s3_addr_reg;
    assign wdata = clr_reg ? {EPOCH_CLEAR, {(DW - EPOCH_W){1'b0}}}
                           : {epoch_reg, cnt_new, first_new};

    assign res_valid       = res_valid_reg;
    assign degree_so_far   = res_deg_reg;
    assign shortest_length = res_len_reg;
    assign is_final        = res_final_reg;
    assign overflow        = res_ovf_reg;

endmodule

`default_nettype wire

FILE: sv/shortest_max_degree_span_top.sv
// Shortest span of maximal degree, streamed.
// Item channel (item_valid / item_stall): one array element per transaction,
// value and last_item; last_item marks the final element of an array.
// Result channel (res_valid / res_stall): one result per item, in order:
// running degree, shortest span of a value of that degree, is_final, overflow.
// An item passes stages s1, s2 and s3, then the result register. Throughput:
// one item per cycle while no result stall or sweep holds items, set by the
// single read-modify-write of the count/first-position memory per item, with
// a bypass for back-to-back hits. Reset: scalar state clears at once; the
// memory is swept over all VALUE_COUNT entries (item_stall high), so no item
// is taken until that pass is over. Arrays are told apart by an 8-bit tag;
// every 255th final item starts the same memory sweep.
// A stalled result holds its fields; items keep being taken until the three
// internal stages are full, then item_stall rises.
`default_nettype none

module shortest_max_degree_span_top #(
    parameter int VALUE_COUNT = 4096,
    parameter int MAX_LEN     = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [smds_pkg::VAL_W-1:0]    value,
    input  logic                          last_item,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [smds_pkg::CNT_W-1:0]    degree_so_far,
    output logic [smds_pkg::CNT_W-1:0]    shortest_length,
    output logic                          is_final,
    output logic                          overflow
);
    import smds_pkg::*;

    localparam int AW = $clog2(VALUE_COUNT);
    localparam int PW = $clog2(MAX_LEN);
    localparam int DW = EPOCH_W + CNT_W + PW;

    item_ctl_t       s2_ctl;
    logic [AW-1:0]   s2_addr;
    logic            s2_adv;
    logic            hold;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [DW-1:0]   wdata;
    logic [DW-1:0]   rdata;

    smds_index #(
        .VALUE_COUNT (VALUE_COUNT),
        .AW          (AW)
    ) u_index (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .value      (value),
        .last_item  (last_item),
        .hold       (hold),
        .s2_adv     (s2_adv),
        .item_stall (item_stall),
        .s2_ctl     (s2_ctl),
        .s2_addr    (s2_addr)
    );

    smds_ram #(
        .DEPTH (VALUE_COUNT),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (s2_adv),
        .raddr (s2_addr),
        .rdata (rdata)
    );

    smds_update #(
        .VALUE_COUNT (VALUE_COUNT),
        .MAX_LEN     (MAX_LEN),
        .AW          (AW),
        .PW          (PW),
        .DW          (DW)
    ) u_update (
        .clk             (clk),
        .rst_n           (rst_n),
        .s2_ctl          (s2_ctl),
        .s2_addr         (s2_addr),
        .rdata           (rdata),
        .res_stall       (res_stall),
        .s2_adv          (s2_adv),
        .hold            (hold),
        .we              (we),
        .waddr           (waddr),
        .wdata           (wdata),
        .res_valid       (res_valid),
        .degree_so_far   (degree_so_far),
        .shortest_length (shortest_length),
        .is_final        (is_final),
        .overflow        (overflow)
    );

endmodule

`default_nettype wire

FILE: sv/smds_checker.sv
`default_nettype none
`include "assert_macros.svh"

module smds_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic [smds_pkg::CNT_W-1:0]    degree_so_far,
    input  logic [smds_pkg::CNT_W-1:0]    shortest_length,
    input  logic                          is_final,
    input  logic                          overflow
);
    import smds_pkg::*;

    logic               res_take;
    logic               res_wait;
    logic [2*CNT_W+1:0] res_bits;
    logic               head_ok;
    logic               deg_ok;
    logic               busy;
    logic               head_reg, head_next;
    logic [CNT_W-1:0]   prev_deg_reg, prev_deg_next;
    logic               item_take;

    assign res_take  = res_valid && !res_stall;
    assign res_wait  = res_valid && res_stall;
    assign item_take = item_valid && !item_stall;
    assign busy      = res_valid || item_take;
    assign res_bits  = {degree_so_far, shortest_length, is_final, overflow};
    assign head_ok   = (degree_so_far == CNT_W'(1)) && (shortest_length == CNT_W'(1))
                       && !overflow;
    assign deg_ok    = (degree_so_far >= prev_deg_reg);

    // head: next result opens a new array
    always_comb
    begin
        head_next     = head_reg;
        prev_deg_next = prev_deg_reg;
        if (res_take)
        begin
            head_next     = is_final;
            prev_deg_next = degree_so_far;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= 1'b1;
            prev_deg_reg <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            prev_deg_reg <= prev_deg_next;
        end
    end

    `SMDS_ASSERT_CLK(a_res_hold, clk, rst_n, res_wait |=> res_valid, "stalled result dropped")
    `SMDS_ASSERT_CLK(a_res_stable, clk, rst_n, res_wait |=> $stable(res_bits), "result changed")
    `SMDS_ASSERT_CLK(a_head, clk, rst_n, res_valid && head_reg |-> head_ok, "bad first result")
    `SMDS_ASSERT_CLK(a_deg_mono, clk, rst_n, res_valid && !head_reg |-> deg_ok, "degree fell")
    `SMDS_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |-> !busy, "activity during reset")

endmodule

bind shortest_max_degree_span_top smds_checker u_smds_checker (.*);

`default_nettype wire
